// ----- src/text_console_glyph_renderer_unit_assert.svh -----
// Assertion macros for the glyph renderer. They sample on clk_i and are
// disabled while rst_ni is low, so they rely on those names in the user scope.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tcgr_pkg.sv -----
package tcgr_pkg;

  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int GLYPH_WIDTH      = 8;
  localparam int TAB_WIDTH        = 8;
  localparam int GLYPH_COUNT      = 256;

  localparam int ROW_W  = 8;
  localparam int COL_W  = 9;
  localparam int PROW_W = 12;
  localparam int COLS_W = 10;
  localparam int ROWS_W = 9;
  localparam int FG_W   = 32;

  typedef enum logic [1:0] {
    MODE_PRINT = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_CARET = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_FG   = 2'd2
  } reg_e;

  localparam logic KIND_GLYPH  = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [COLS_W-1:0] COLS_RESET = 10'd80;
  localparam logic [COLS_W-1:0] COLS_MIN   = 10'd8;
  localparam logic [COLS_W-1:0] COLS_MAX   = 10'd512;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd25;
  localparam logic [ROWS_W-1:0] ROWS_MIN   = 9'd2;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = 9'd256;
  localparam logic [FG_W-1:0]   FG_RESET   = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_STEP   = 2'd1,
    ST_SCROLL = 2'd2,
    ST_EMIT   = 2'd3
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic emit_scroll;
    logic emit_row;
  } cmd_t;

  typedef struct packed {
    logic scroll;
    logic line_last;
    logic slot_free;
  } sts_t;

endpackage

// ----- src/tcgr_in_if.sv -----
interface tcgr_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [7:0]              char_code;
  logic [3:0]              font_line;
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] font_bits;

  modport source (output valid, mode, char_code, font_line, font_bits, input ready);
  modport sink   (input valid, mode, char_code, font_line, font_bits, output ready);
endinterface

// ----- src/tcgr_out_if.sv -----
interface tcgr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [tcgr_pkg::PROW_W-1:0]      pixel_row;
  logic [tcgr_pkg::COL_W-1:0]       cell_col;
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] row_bits;
  logic [tcgr_pkg::FG_W-1:0]        color;
  logic                             last;

  modport source (output valid, kind, pixel_row, cell_col, row_bits, color, last,
                  input ready);
  modport sink   (input valid, kind, pixel_row, cell_col, row_bits, color, last,
                  output ready);
endinterface

// ----- src/tcgr_ctrl.sv -----
module tcgr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  input  tcgr_pkg::sts_t      sts_i,
  output tcgr_pkg::cmd_t      cmd_o
);

  tcgr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tcgr_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (tcgr_pkg::mode_e'(in_mode_i))
            tcgr_pkg::MODE_PRINT: state_d = tcgr_pkg::ST_STEP;
            tcgr_pkg::MODE_CARET: state_d = tcgr_pkg::ST_EMIT;
            default:              state_d = tcgr_pkg::ST_IDLE;
          endcase
        end
      end
      tcgr_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.scroll ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_EMIT;
      end
      tcgr_pkg::ST_SCROLL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_scroll = 1'b1;
          state_d           = tcgr_pkg::ST_EMIT;
        end
      end
      tcgr_pkg::ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_row = 1'b1;
          if (sts_i.line_last) begin
            state_d = tcgr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = tcgr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/tcgr_datapath.sv -----
module tcgr_datapath #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcgr_pkg::cmd_t                    cmd_i,
  output tcgr_pkg::sts_t                    sts_o,
  input  logic [1:0]                        mode_i,
  input  logic [7:0]                        char_code_i,
  input  logic [3:0]                        font_line_i,
  input  logic [tcgr_pkg::GLYPH_WIDTH-1:0]  font_bits_i,
  input  logic [tcgr_pkg::COLS_W-1:0]       eff_cols_i,
  input  logic [tcgr_pkg::ROWS_W-1:0]       eff_rows_i,
  input  logic [tcgr_pkg::FG_W-1:0]         fg_color_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_kind_o,
  output logic [tcgr_pkg::PROW_W-1:0]       out_pixel_row_o,
  output logic [tcgr_pkg::COL_W-1:0]        out_cell_col_o,
  output logic [tcgr_pkg::GLYPH_WIDTH-1:0]  out_row_bits_o,
  output logic [tcgr_pkg::FG_W-1:0]         out_color_o,
  output logic                              out_last_o
);

  localparam int DEPTH  = tcgr_pkg::GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINE_W = $clog2(GLYPH_HEIGHT);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(GLYPH_HEIGHT - 1);

  // Glyph store: one byte per glyph row.
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] font_mem [DEPTH];

  logic [tcgr_pkg::ROW_W-1:0] caret_row_q;
  logic [tcgr_pkg::COL_W-1:0] caret_col_q;
  logic [tcgr_pkg::ROW_W-1:0] cell_row_q;
  logic [tcgr_pkg::COL_W-1:0] cell_col_q;
  logic [7:0]                 char_q;
  logic                       solid_q;
  logic [LINE_W-1:0]          line_q;
  logic [ADDR_W-1:0]          rd_addr_q, rd_addr_d;
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] rdata_q;

  logic                       is_load, is_draw, wr_en, rd_en, line_last;
  logic [ADDR_W-1:0]          wr_addr, glyph_addr;
  logic [7:0]                 glyph;
  logic [tcgr_pkg::ROWS_W-1:0] rows_m1;
  logic [tcgr_pkg::COLS_W-1:0] cols_m1;
  logic [tcgr_pkg::ROW_W-1:0] row_clamp;
  logic [tcgr_pkg::COL_W-1:0] col_clamp;
  logic [tcgr_pkg::COLS_W-1:0] col_ext, nc, nc_w;
  logic [tcgr_pkg::ROWS_W-1:0] row_ext, nr, nr_w, nr_s;
  logic                       wrap, step_scroll;
  logic [13:0]                prow_full;

  assign is_load = cmd_i.accept && (mode_i == tcgr_pkg::MODE_LOAD);
  assign is_draw = cmd_i.accept &&
                   ((mode_i == tcgr_pkg::MODE_PRINT) || (mode_i == tcgr_pkg::MODE_CARET));
  assign wr_en   = is_load && (32'(font_line_i) < GLYPH_HEIGHT);
  assign wr_addr = ADDR_W'(char_code_i) * ADDR_W'(GLYPH_HEIGHT) + ADDR_W'(font_line_i);

  // Tab, line feed and carriage return are drawn as a space.
  always_comb begin
    if (char_code_i inside {tcgr_pkg::CHAR_TAB, tcgr_pkg::CHAR_LF, tcgr_pkg::CHAR_CR}) begin
      glyph = tcgr_pkg::CHAR_SPACE;
    end else begin
      glyph = char_code_i;
    end
  end
  assign glyph_addr = ADDR_W'(glyph) * ADDR_W'(GLYPH_HEIGHT);

  assign line_last = (line_q == LINE_LAST);
  // The next glyph row is fetched while the current one is being handed out.
  assign rd_en     = cmd_i.accept || (cmd_i.emit_row && !line_last);
  assign rd_addr_d = cmd_i.accept ? glyph_addr : rd_addr_q + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      font_mem[wr_addr] <= font_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q   <= font_mem[rd_addr_d];
      rd_addr_q <= rd_addr_d;
    end
  end

  // Pull a caret left outside a shrunken screen back onto its last row/column.
  assign rows_m1   = eff_rows_i - 9'd1;
  assign cols_m1   = eff_cols_i - 10'd1;
  assign row_clamp = ({1'b0, caret_row_q} >= eff_rows_i) ? rows_m1[tcgr_pkg::ROW_W-1:0]
                                                         : caret_row_q;
  assign col_clamp = ({1'b0, caret_col_q} >= eff_cols_i) ? cols_m1[tcgr_pkg::COL_W-1:0]
                                                         : caret_col_q;

  // Caret movement for a print; the caret is already clamped here.
  always_comb begin
    col_ext = {1'b0, caret_col_q};
    row_ext = {1'b0, caret_row_q};
    nr      = row_ext;
    case (char_q)
      tcgr_pkg::CHAR_TAB: begin
        nc = (col_ext + 10'(tcgr_pkg::TAB_WIDTH)) & ~10'(tcgr_pkg::TAB_WIDTH - 1);
      end
      tcgr_pkg::CHAR_LF: begin
        nc = '0;
        nr = row_ext + 9'd1;
      end
      tcgr_pkg::CHAR_CR: begin
        nc = '0;
      end
      default: begin
        nc = col_ext + 10'd1;
      end
    endcase
    wrap        = (nc >= eff_cols_i);
    nc_w        = wrap ? nc - eff_cols_i : nc;
    nr_w        = wrap ? nr + 9'd1 : nr;
    step_scroll = (nr_w >= eff_rows_i);
    nr_s        = step_scroll ? nr_w - 9'd1 : nr_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caret_row_q <= '0;
      caret_col_q <= '0;
      line_q      <= '0;
    end else begin
      if (is_draw) begin
        caret_row_q <= row_clamp;
        caret_col_q <= col_clamp;
        line_q      <= '0;
      end else if (cmd_i.step) begin
        caret_row_q <= nr_s[tcgr_pkg::ROW_W-1:0];
        caret_col_q <= nc_w[tcgr_pkg::COL_W-1:0];
      end else if (cmd_i.emit_row) begin
        line_q <= line_q + LINE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_draw) begin
      cell_row_q <= row_clamp;
      cell_col_q <= col_clamp;
      char_q     <= char_code_i;
      solid_q    <= (mode_i == tcgr_pkg::MODE_CARET);
    end else if (cmd_i.step && step_scroll) begin
      cell_row_q <= cell_row_q - 8'd1;
    end
  end

  assign prow_full = 14'(cell_row_q) * 14'(GLYPH_HEIGHT) + 14'(line_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_row || cmd_i.emit_scroll) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_scroll) begin
      out_kind_o      <= tcgr_pkg::KIND_SCROLL;
      out_pixel_row_o <= '0;
      out_cell_col_o  <= '0;
      out_row_bits_o  <= '0;
      out_color_o     <= '0;
      out_last_o      <= 1'b0;
    end else if (cmd_i.emit_row) begin
      out_kind_o      <= tcgr_pkg::KIND_GLYPH;
      out_pixel_row_o <= prow_full[tcgr_pkg::PROW_W-1:0];
      out_cell_col_o  <= cell_col_q;
      out_row_bits_o  <= solid_q ? '1 : rdata_q;
      out_color_o     <= fg_color_i;
      out_last_o      <= line_last;
    end
  end

  assign sts_o.scroll    = step_scroll;
  assign sts_o.line_last = line_last;
  assign sts_o.slot_free = !out_valid_o || out_ready_i;

endmodule

// ----- src/text_console_glyph_renderer_unit.sv -----
// Sequence: a font load is written at its accept and the block stays idle; a caret draw
// goes on to emit its glyph rows; a print first steps the caret, then sends a scroll
// command if it runs off the bottom, then its glyph rows. One item at a time: the next is
// taken only after the last row, and rows go out one per cycle while the output is free.
// Reset (rst_ni, asynchronous, active low) clears the caret, the sequencer and the
// output valid, and restores the registers; the glyph store is not cleared.
`include "text_console_glyph_renderer_unit_assert.svh"

module text_console_glyph_renderer_unit #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcgr_in_if.sink             in_i,
  tcgr_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers, held as written.
  logic [tcgr_pkg::COLS_W-1:0] cols_q;
  logic [tcgr_pkg::ROWS_W-1:0] rows_q;
  logic [tcgr_pkg::FG_W-1:0]   fg_q;

  // Saturated screen size actually used by the datapath.
  logic [tcgr_pkg::COLS_W-1:0] eff_cols;
  logic [tcgr_pkg::ROWS_W-1:0] eff_rows;
  logic                        cfg_wr;

  tcgr_pkg::cmd_t cmd;
  tcgr_pkg::sts_t sts;

  // Summaries of the controller's commands, used by the checks at the end.
  logic emitting;
  logic busy;
  logic row_final;

  // The port never waits: a write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcgr_pkg::COLS_RESET;
      rows_q <= tcgr_pkg::ROWS_RESET;
      fg_q   <= tcgr_pkg::FG_RESET;
    end else if (cfg_wr) begin
      case (tcgr_pkg::reg_e'(paddr[3:2]))
        tcgr_pkg::REG_COLS: cols_q <= pwdata[tcgr_pkg::COLS_W-1:0];
        tcgr_pkg::REG_ROWS: rows_q <= pwdata[tcgr_pkg::ROWS_W-1:0];
        tcgr_pkg::REG_FG:   fg_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tcgr_pkg::reg_e'(paddr[3:2]))
      tcgr_pkg::REG_COLS: prdata = 32'(cols_q);
      tcgr_pkg::REG_ROWS: prdata = 32'(rows_q);
      tcgr_pkg::REG_FG:   prdata = fg_q;
      default:            prdata = '0;
    endcase
  end

  // Out-of-range sizes are pulled into the legal screen range.
  always_comb begin
    if (cols_q < tcgr_pkg::COLS_MIN) begin
      eff_cols = tcgr_pkg::COLS_MIN;
    end else if (cols_q > tcgr_pkg::COLS_MAX) begin
      eff_cols = tcgr_pkg::COLS_MAX;
    end else begin
      eff_cols = cols_q;
    end
    if (rows_q < tcgr_pkg::ROWS_MIN) begin
      eff_rows = tcgr_pkg::ROWS_MIN;
    end else if (rows_q > tcgr_pkg::ROWS_MAX) begin
      eff_rows = tcgr_pkg::ROWS_MAX;
    end else begin
      eff_rows = rows_q;
    end
  end

  // The controller sequences a print as accept, caret step, optional scroll command, then
  // one glyph row per cycle while the output slot is free; a caret draw skips step/scroll.
  tcgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the caret, the glyph store and the output register.
  tcgr_datapath #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .char_code_i     (in_i.char_code),
    .font_line_i     (in_i.font_line),
    .font_bits_i     (in_i.font_bits),
    .eff_cols_i      (eff_cols),
    .eff_rows_i      (eff_rows),
    .fg_color_i      (fg_q),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_kind_o      (out_o.kind),
    .out_pixel_row_o (out_o.pixel_row),
    .out_cell_col_o  (out_o.cell_col),
    .out_row_bits_o  (out_o.row_bits),
    .out_color_o     (out_o.color),
    .out_last_o      (out_o.last)
  );

  assign emitting  = cmd.emit_scroll || cmd.emit_row;
  assign busy      = cmd.step || emitting;
  assign row_final = cmd.emit_row && sts.line_last;

  // No new transaction is taken while an item is still being worked on.
  `TCGR_ASSERT_IMP(a_busy_blocks_input, busy, !in_i.ready, "input accepted while busy")
  // A result is only produced into a free output slot.
  `TCGR_ASSERT_IMP(a_emit_free_slot, emitting, !out_o.valid || out_o.ready, "slot taken")
  // The final glyph row of a cell is presented with last set.
  `TCGR_ASSERT_NXT(a_final_last, row_final, out_o.valid && out_o.last, "row without last")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // Clock period, reset length and the cycles allowed for work still in flight once
  // every expected transaction has arrived.
  localparam int CLK_HALF_NS     = 6;
  localparam int RESET_CYCLES    = 5;
  localparam int SETTLE_CYCLES   = 24;
  localparam int TIMEOUT_NS      = 10_000_000;
  localparam int GLYPH_HEIGHT    = tcgr_pkg::GLYPH_HEIGHT_DEF;
  localparam int STORE_DEPTH     = tcgr_pkg::GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 8;

  // The fourth mode code has no meaning; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                       mode;
    logic [7:0]                       char_code;
    logic [3:0]                       font_line;
    logic [tcgr_pkg::GLYPH_WIDTH-1:0] font_bits;
  } glyph_cmd_t;

  typedef struct packed {
    logic                             kind;
    logic [tcgr_pkg::PROW_W-1:0]      pixel_row;
    logic [tcgr_pkg::COL_W-1:0]       cell_col;
    logic [tcgr_pkg::GLYPH_WIDTH-1:0] row_bits;
    logic [tcgr_pkg::FG_W-1:0]        color;
    logic                             last;
  } glyph_write_t;

  // The scoreboard keeps its own copy of the caret, the registers and the glyph store,
  // works out the row writes that each accepted command must cause, and compares every
  // transaction leaving the block with the oldest of them.
  class glyph_scoreboard;
    glyph_write_t                     expected_writes[$];
    int unsigned                      errors;
    logic [tcgr_pkg::COLS_W-1:0]      cols_reg;
    logic [tcgr_pkg::ROWS_W-1:0]      rows_reg;
    logic [tcgr_pkg::FG_W-1:0]        fg_reg;
    int unsigned                      caret_row;
    int unsigned                      caret_col;
    logic [tcgr_pkg::GLYPH_WIDTH-1:0] font_mem [STORE_DEPTH];
    bit                               font_set [STORE_DEPTH];

    function new();
      errors    = 0;
      cols_reg  = tcgr_pkg::COLS_RESET;
      rows_reg  = tcgr_pkg::ROWS_RESET;
      fg_reg    = tcgr_pkg::FG_RESET;
      caret_row = 0;
      caret_col = 0;
      foreach (font_set[i]) font_set[i] = 1'b0;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void set_register(tcgr_pkg::reg_e idx, logic [31:0] value);
      case (idx)
        tcgr_pkg::REG_COLS: cols_reg = value[tcgr_pkg::COLS_W-1:0];
        tcgr_pkg::REG_ROWS: rows_reg = value[tcgr_pkg::ROWS_W-1:0];
        tcgr_pkg::REG_FG:   fg_reg   = value[tcgr_pkg::FG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned screen_cols();
      if (cols_reg < tcgr_pkg::COLS_MIN) return 32'(tcgr_pkg::COLS_MIN);
      if (cols_reg > tcgr_pkg::COLS_MAX) return 32'(tcgr_pkg::COLS_MAX);
      return 32'(cols_reg);
    endfunction

    function int unsigned screen_rows();
      if (rows_reg < tcgr_pkg::ROWS_MIN) return 32'(tcgr_pkg::ROWS_MIN);
      if (rows_reg > tcgr_pkg::ROWS_MAX) return 32'(tcgr_pkg::ROWS_MAX);
      return 32'(rows_reg);
    endfunction

    // True when every line of the glyph that a print of ch would draw has been loaded.
    function bit glyph_complete(logic [7:0] ch);
      logic [7:0] g;
      g = (ch == tcgr_pkg::CHAR_TAB || ch == tcgr_pkg::CHAR_LF || ch == tcgr_pkg::CHAR_CR)
          ? tcgr_pkg::CHAR_SPACE : ch;
      for (int y = 0; y < GLYPH_HEIGHT; y++)
        if (!font_set[g * GLYPH_HEIGHT + y]) return 1'b0;
      return 1'b1;
    endfunction

    function void push_cell(int unsigned row, int unsigned col, bit solid, logic [7:0] g);
      glyph_write_t w;
      for (int y = 0; y < GLYPH_HEIGHT; y++) begin
        w.kind      = tcgr_pkg::KIND_GLYPH;
        w.pixel_row = tcgr_pkg::PROW_W'(row * GLYPH_HEIGHT + y);
        w.cell_col  = tcgr_pkg::COL_W'(col);
        w.row_bits  = solid ? 8'hFF : font_mem[g * GLYPH_HEIGHT + y];
        w.color     = fg_reg;
        w.last      = (y == GLYPH_HEIGHT - 1);
        expected_writes.push_back(w);
      end
    endfunction

    function void note_command(glyph_cmd_t cmd);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  r;
      int unsigned  c;
      logic [7:0]   g;
      glyph_write_t scroll;
      rows = screen_rows();
      cols = screen_cols();
      case (cmd.mode)
        tcgr_pkg::MODE_LOAD: begin
          font_mem[cmd.char_code * GLYPH_HEIGHT + cmd.font_line] = cmd.font_bits;
          font_set[cmd.char_code * GLYPH_HEIGHT + cmd.font_line] = 1'b1;
        end
        tcgr_pkg::MODE_CARET: begin
          if (caret_row >= rows) caret_row = rows - 1;
          if (caret_col >= cols) caret_col = cols - 1;
          push_cell(caret_row, caret_col, 1'b1, 8'h00);
        end
        tcgr_pkg::MODE_PRINT: begin
          // A shrunken screen pulls the caret back inside before anything moves.
          if (caret_row >= rows) caret_row = rows - 1;
          if (caret_col >= cols) caret_col = cols - 1;
          r = caret_row;
          c = caret_col;
          g = cmd.char_code;
          case (cmd.char_code)
            tcgr_pkg::CHAR_TAB: begin
              caret_col = (caret_col + tcgr_pkg::TAB_WIDTH) & ~(tcgr_pkg::TAB_WIDTH - 1);
              g = tcgr_pkg::CHAR_SPACE;
            end
            tcgr_pkg::CHAR_LF: begin
              caret_row = caret_row + 1;
              caret_col = 0;
              g = tcgr_pkg::CHAR_SPACE;
            end
            tcgr_pkg::CHAR_CR: begin
              caret_col = 0;
              g = tcgr_pkg::CHAR_SPACE;
            end
            default: caret_col = caret_col + 1;
          endcase
          if (caret_col >= cols) begin
            caret_col = caret_col - cols;
            caret_row = caret_row + 1;
          end
          // Running off the bottom scrolls the screen, and the cell just printed moves
          // up with it.
          if (caret_row >= rows) begin
            scroll = '0;
            scroll.kind = tcgr_pkg::KIND_SCROLL;
            expected_writes.push_back(scroll);
            caret_row = caret_row - 1;
            r = r - 1;
          end
          push_cell(r, c, 1'b0, g);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      errors++;
    endtask

    task check_write(glyph_write_t got);
      glyph_write_t want;
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected transaction (kind)", 32'd0, 32'(got.kind));
        return;
      end
      want = expected_writes.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("kind", 32'(want.kind), 32'(got.kind));
      if (got.pixel_row !== want.pixel_row)
        report_mismatch("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
      if (got.cell_col !== want.cell_col)
        report_mismatch("cell_col", 32'(want.cell_col), 32'(got.cell_col));
      if (got.row_bits !== want.row_bits)
        report_mismatch("row_bits", 32'(want.row_bits), 32'(got.row_bits));
      if (got.color !== want.color)
        report_mismatch("color", want.color, got.color);
      if (got.last !== want.last)
        report_mismatch("last", 32'(want.last), 32'(got.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcgr_in_if  in_bus ();
  tcgr_out_if out_bus ();

  glyph_scoreboard sb = new();

  // Glyphs whose sixteen lines are all loaded, so that printing them is allowed.
  logic [7:0]  ready_glyphs[$];
  int unsigned item_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  text_console_glyph_renderer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // A hard ceiling on the run, far beyond the slowest correct one.
  initial begin
    #(TIMEOUT_NS);
    $display("** text_console_glyph_renderer_unit: FAILED **");
    $finish;
  end

  // Receiving side: every transaction is checked at the edge that accepts it, using the
  // values sampled before this edge's updates; ready is then redrawn for the next cycle
  // according to the stall rate of the current phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_write({out_bus.kind, out_bus.pixel_row, out_bus.cell_col,
                      out_bus.row_bits, out_bus.color, out_bus.last});
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic glyph_cmd_t make_cmd(logic [1:0] mode, logic [7:0] ch,
                                          logic [3:0] line, logic [7:0] bits);
    glyph_cmd_t cmd;
    cmd.mode      = mode;
    cmd.char_code = ch;
    cmd.font_line = line;
    cmd.font_bits = bits;
    return cmd;
  endfunction

  // Offers one command, after a random number of idle cycles, and holds it until the
  // block takes it. Valid is only ever lowered in a cycle where it is not raised again,
  // so back-to-back commands keep valid high throughout.
  task automatic send_cmd(glyph_cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= cmd.mode;
    in_bus.char_code <= cmd.char_code;
    in_bus.font_line <= cmd.font_line;
    in_bus.font_bits <= cmd.font_bits;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_command(cmd);
    if (cmd.mode != MODE_UNUSED) item_count++;
  endtask

  task automatic print_char(logic [7:0] ch);
    send_cmd(make_cmd(tcgr_pkg::MODE_PRINT, ch, 4'($urandom_range(15)),
                      8'($urandom_range(255))));
  endtask

  task automatic draw_caret();
    send_cmd(make_cmd(tcgr_pkg::MODE_CARET, 8'($urandom_range(255)),
                      4'($urandom_range(15)), 8'($urandom_range(255))));
  endtask

  task automatic send_ignored();
    send_cmd(make_cmd(MODE_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)),
                      8'($urandom_range(255))));
  endtask

  task automatic load_byte(logic [7:0] ch, logic [3:0] line, logic [7:0] bits);
    send_cmd(make_cmd(tcgr_pkg::MODE_LOAD, ch, line, bits));
  endtask

  task automatic load_glyph(logic [7:0] ch);
    for (int y = 0; y < GLYPH_HEIGHT; y++)
      load_byte(ch, 4'(y), 8'($urandom_range(255)));
    ready_glyphs.push_back(ch);
  endtask

  // A setup phase, then an access phase; the register takes the value at the access edge.
  // The trailing idle cycle keeps psel from being lowered and raised in one time step.
  task automatic write_register(tcgr_pkg::reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // The sender holds off until every expected transaction has come out, then gives a
  // font load that produces nothing visible time to finish as well.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen(logic [31:0] cols, logic [31:0] rows, logic [31:0] fg);
    write_register(tcgr_pkg::REG_COLS, cols);
    write_register(tcgr_pkg::REG_ROWS, rows);
    write_register(tcgr_pkg::REG_FG, fg);
  endtask

  // A character to print: control characters are favoured, since they steer the caret,
  // and anything else falls back on a glyph known to be fully loaded.
  function automatic logic [7:0] pick_char();
    logic [7:0] ch;
    case ($urandom_range(5))
      0: ch = tcgr_pkg::CHAR_TAB;
      1: ch = tcgr_pkg::CHAR_LF;
      2: ch = tcgr_pkg::CHAR_CR;
      default: begin
        ch = 8'($urandom_range(255));
        if (!sb.glyph_complete(ch))
          ch = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
      end
    endcase
    return ch;
  endfunction

  // One random step of console activity. Most of it is text, often whole lines ending
  // in a newline so that the caret travels to the bottom and the screen scrolls; the
  // remainder reloads font bytes, loads fresh glyphs, scribbles partial glyphs that
  // are never printed, and offers the meaningless mode code.
  task automatic random_activity();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 45) begin
      print_char(pick_char());
    end else if (pick < 60) begin
      len = $urandom_range(2, 8);
      repeat (len) print_char(pick_char());
      print_char(tcgr_pkg::CHAR_LF);
    end else if (pick < 70) begin
      draw_caret();
    end else if (pick < 80) begin
      load_byte(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)],
                4'($urandom_range(15)), 8'($urandom_range(255)));
    end else if (pick < 84) begin
      load_glyph(8'($urandom_range(255)));
    end else if (pick < 92) begin
      load_byte(8'($urandom_range(255)), 4'($urandom_range(15)), 8'($urandom_range(255)));
    end else begin
      send_ignored();
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.mode      <= tcgr_pkg::MODE_PRINT;
    in_bus.char_code <= '0;
    in_bus.font_line <= '0;
    in_bus.font_bits <= '0;
    item_count       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The space glyph must be complete before any control character is printed; the
    // two extreme glyph codes get font bytes at both extremes and single-pixel edges.
    load_glyph(tcgr_pkg::CHAR_SPACE);
    load_glyph(8'h00);
    load_glyph(8'hFF);
    load_byte(8'hFF, 4'd0, 8'hFF);
    load_byte(8'h00, 4'd15, 8'h00);
    load_byte(8'h00, 4'd1, 8'h80);
    load_byte(8'h00, 4'd2, 8'h01);

    // Default screen: plain characters, an ignored mode, the caret, and the caret
    // moved by tab, newline and carriage return.
    print_char(8'h00);
    print_char(8'hFF);
    print_char(tcgr_pkg::CHAR_SPACE);
    send_ignored();
    draw_caret();
    print_char(tcgr_pkg::CHAR_TAB);
    print_char(tcgr_pkg::CHAR_TAB);
    print_char(tcgr_pkg::CHAR_LF);
    print_char(tcgr_pkg::CHAR_LF);
    print_char(tcgr_pkg::CHAR_LF);
    print_char(tcgr_pkg::CHAR_CR);
    print_char(tcgr_pkg::CHAR_TAB);
    load_byte(8'hFF, 4'd15, 8'h5A);
    print_char(8'hFF);
    wait_idle();

    // Smallest screen with the caret left outside it: it is pulled back in, a tab past
    // the last column wraps onto the bottom row and scrolls, and a full row wraps.
    set_screen(32'd8, 32'd2, 32'h0000_0000);
    print_char(8'h00);
    draw_caret();
    print_char(tcgr_pkg::CHAR_TAB);
    repeat (9) print_char(8'hFF);
    print_char(tcgr_pkg::CHAR_LF);
    print_char(tcgr_pkg::CHAR_CR);
    wait_idle();

    // Register values above range are saturated to the largest screen.
    set_screen(32'h0000_03FF, 32'h0000_01FF, 32'hFFFF_FFFF);
    repeat (3) print_char(8'hFF);
    draw_caret();
    wait_idle();

    // Random phases: each one settles the screen size and colour while the block is
    // idle, then runs with its own mix of sender gaps and receiver stalls.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: set_screen(32'(tcgr_pkg::COLS_RESET), 32'(tcgr_pkg::ROWS_RESET), $urandom());
        1: set_screen(32'd8, 32'd2, 32'h0000_0000);
        2: set_screen(32'd0, 32'd0, $urandom());
        3: set_screen(32'd13, 32'd3, $urandom());
        4: set_screen(32'd1023, 32'd511, $urandom());
        5: set_screen($urandom_range(8, 24), $urandom_range(2, 5), $urandom());
        6: set_screen(32'd512, 32'd256, 32'hFFFF_FFFF);
        default: set_screen(32'd9, 32'd2, $urandom());
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      phase_start = item_count;
      while (item_count - phase_start < ITEMS_PER_PHASE) random_activity();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** text_console_glyph_renderer_unit: PASSED **");
    end else begin
      $display("** text_console_glyph_renderer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tcgr_pkg.sv
src/tcgr_in_if.sv
src/tcgr_out_if.sv
src/tcgr_ctrl.sv
src/tcgr_datapath.sv
src/text_console_glyph_renderer_unit.sv
sim/testbench.sv
